// ===== hw/rtl/ewh_pkg.sv =====
// ----------------------------------------------------------------------------
// ewh_pkg
// Shared types and constants for the equal-width histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ewh_pkg;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int VALUE_W     = 11;
    localparam int INDEX_W     = 7;
    localparam int OUT_COUNT_W = 32;

    // defaults for the top-level parameters
    localparam int NUM_BINS_DEF    = 128;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [VALUE_W-1:0] BIN_WIDTH_RESET = 11'd10;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [INDEX_W-1:0]   echo_index;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ewh_queue.sv =====
// ----------------------------------------------------------------------------
// ewh_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ewh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign in_ready  = (fill_reg != FILL_W'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ewh_front.sv =====
// ----------------------------------------------------------------------------
// ewh_front
// Accepts input transactions, holds the bin width register and works out the
// target bin with a bit-serial divider, then hands a command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ewh_front #(
    parameter int NUM_BINS = ewh_pkg::NUM_BINS_DEF,
    parameter int BIN_W    = $clog2(ewh_pkg::NUM_BINS_DEF)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ewh_pkg::OP_W-1:0]          s_op,
    input  wire logic [ewh_pkg::VALUE_W-1:0]       s_sample_value,
    input  wire logic [ewh_pkg::INDEX_W-1:0]       s_read_bin,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ewh_pkg::VALUE_W-1:0]       cfg_wr_data,
    input  wire logic                              init_busy,
    output logic                                   cmd_valid,
    input  wire logic                              cmd_ready,
    output ewh_pkg::cmd_t                          cmd,
    output logic      [BIN_W-1:0]                  cmd_addr
);

    localparam int VW     = ewh_pkg::VALUE_W;
    localparam int STEP_W = $clog2(VW);
    localparam logic [VW-1:0] LAST_BIN = VW'(NUM_BINS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [VW-1:0]         bin_width_reg;
    logic [VW-1:0]         dvd_reg;
    logic [VW-1:0]         rem_reg;
    logic [STEP_W-1:0]     step_reg;
    ewh_pkg::cmd_t         cmd_reg;
    logic [BIN_W-1:0]      addr_reg;

    logic                  s_fire;
    logic                  div_last;
    logic [VW:0]           trial;
    logic                  fits;
    logic [VW-1:0]         rem_next;
    logic [VW-1:0]         quo;
    logic                  sample_zero;
    logic                  width_zero;
    logic                  read_in_range;

    assign s_ready   = (state_reg == F_IDLE) && !init_busy;
    assign s_fire    = s_valid && s_ready;
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;
    assign cmd_addr  = addr_reg;

    assign sample_zero   = (s_sample_value == '0);
    assign width_zero    = (bin_width_reg == '0);
    assign read_in_range = (32'(s_read_bin) < 32'(NUM_BINS));
    assign div_last      = (step_reg == STEP_W'(VW - 1));

    // one restoring division step: quotient bits shift into the dividend register
    assign trial    = {rem_reg, dvd_reg[VW-1]} - {1'b0, bin_width_reg};
    assign fits     = !trial[VW];
    assign rem_next = fits ? trial[VW-1:0] : {rem_reg[VW-2:0], dvd_reg[VW-1]};
    assign quo      = {dvd_reg[VW-2:0], fits};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_fire) begin
                    if (s_op == ewh_pkg::OP_ADD && !sample_zero && !width_zero) begin
                        state_next = F_DIV;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                if (div_last) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (cmd_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            bin_width_reg <= ewh_pkg::BIN_WIDTH_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                bin_width_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_fire) begin
            cmd_reg.echo_index <= '0;
            rem_reg            <= '0;
            step_reg           <= '0;
            dvd_reg            <= s_sample_value - VW'(1);
            case (s_op)
                ewh_pkg::OP_ADD: begin
                    if (sample_zero) begin
                        cmd_reg.kind <= ewh_pkg::CMD_NONE;
                    end else begin
                        cmd_reg.kind <= ewh_pkg::CMD_ADD;
                        // zero width puts every sample in the last bin
                        addr_reg     <= BIN_W'(LAST_BIN);
                    end
                end
                ewh_pkg::OP_READ: begin
                    cmd_reg.echo_index <= s_read_bin;
                    if (read_in_range) begin
                        cmd_reg.kind <= ewh_pkg::CMD_READ;
                        addr_reg     <= BIN_W'(s_read_bin);
                    end else begin
                        cmd_reg.kind <= ewh_pkg::CMD_NONE;
                    end
                end
                ewh_pkg::OP_CLEAR: begin
                    cmd_reg.kind <= ewh_pkg::CMD_CLEAR;
                end
                default: begin
                    cmd_reg.kind <= ewh_pkg::CMD_NONE;
                end
            endcase
        end else if (state_reg == F_DIV) begin
            dvd_reg  <= quo;
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
            if (div_last) begin
                addr_reg <= (quo > LAST_BIN) ? BIN_W'(LAST_BIN) : BIN_W'(quo);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ewh_back.sv =====
// ----------------------------------------------------------------------------
// ewh_back
// Carries out queued commands on the bin counter memory: read-modify-write
// for samples, reads, and clearing sweeps after reset and on request.
// ----------------------------------------------------------------------------
`default_nettype none

module ewh_back #(
    parameter int NUM_BINS    = ewh_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = ewh_pkg::COUNT_WIDTH_DEF,
    parameter int BIN_W       = $clog2(ewh_pkg::NUM_BINS_DEF)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire ewh_pkg::cmd_t                       cmd,
    input  wire logic [BIN_W-1:0]                    cmd_addr,
    output logic                                     init_busy,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [ewh_pkg::INDEX_W-1:0]         m_bin_index,
    output logic      [ewh_pkg::OUT_COUNT_W-1:0]     m_bin_count,
    output logic                                     m_accepted
);

    localparam int IW = ewh_pkg::INDEX_W;
    localparam int OW = ewh_pkg::OUT_COUNT_W;

    typedef enum logic [4:0] {
        B_INIT  = 5'b00001,
        B_IDLE  = 5'b00010,
        B_LOOK  = 5'b00100,
        B_CLEAR = 5'b01000,
        B_OUT   = 5'b10000
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic [BIN_W-1:0]        clr_addr_reg;
    ewh_pkg::cmd_t           cmd_reg;
    logic [BIN_W-1:0]        addr_reg;
    logic [COUNT_WIDTH-1:0]  rd_data_reg;
    logic [IW-1:0]           m_bin_index_reg;
    logic [OW-1:0]           m_bin_count_reg;
    logic                    m_accepted_reg;

    logic [COUNT_WIDTH-1:0]  count_mem [NUM_BINS];

    logic                    cmd_fire;
    logic                    clr_last;
    logic                    wr_en;
    logic [BIN_W-1:0]        wr_addr;
    logic [COUNT_WIDTH-1:0]  wr_data;
    logic [COUNT_WIDTH-1:0]  inc;

    assign cmd_ready   = (state_reg == B_IDLE);
    assign cmd_fire    = cmd_valid && cmd_ready;
    assign init_busy   = (state_reg == B_INIT);
    assign m_valid     = (state_reg == B_OUT);
    assign m_bin_index = m_bin_index_reg;
    assign m_bin_count = m_bin_count_reg;
    assign m_accepted  = m_accepted_reg;
    assign clr_last    = (clr_addr_reg == BIN_W'(NUM_BINS - 1));

    // saturating increment
    assign inc = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = inc;
        if (state_reg == B_INIT || state_reg == B_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else if (state_reg == B_LOOK && cmd_reg.kind == ewh_pkg::CMD_ADD) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_INIT: begin
                if (clr_last) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (cmd_fire) begin
                    case (cmd.kind) inside
                        ewh_pkg::CMD_ADD, ewh_pkg::CMD_READ: state_next = B_LOOK;
                        ewh_pkg::CMD_CLEAR:                  state_next = B_CLEAR;
                        default:                             state_next = B_OUT;
                    endcase
                end
            end
            B_LOOK: state_next = B_OUT;
            B_CLEAR: begin
                if (clr_last) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (m_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_INIT;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_INIT || state_reg == B_CLEAR) begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + BIN_W'(1);
            end
        end
    end

    // counter memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem[wr_addr] <= wr_data;
        end
        if (cmd_fire) begin
            rd_data_reg <= count_mem[cmd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_fire) begin
            cmd_reg         <= cmd;
            addr_reg        <= cmd_addr;
            m_bin_index_reg <= cmd.echo_index;
            m_bin_count_reg <= '0;
            m_accepted_reg  <= 1'b0;
        end else if (state_reg == B_LOOK) begin
            if (cmd_reg.kind == ewh_pkg::CMD_ADD) begin
                m_bin_index_reg <= IW'(addr_reg);
                m_bin_count_reg <= OW'(inc);
                m_accepted_reg  <= 1'b1;
            end else begin
                m_bin_count_reg <= OW'(rd_data_reg);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/equal_width_histogram.sv =====
// ----------------------------------------------------------------------------
// equal_width_histogram
// Equal-width histogram engine: sample, read and clear transactions on a
// counter memory, one result transaction for every input transaction.
// ----------------------------------------------------------------------------
// After reset the counter memory is swept to zero, during which s_ready stays
// low. A sample transaction passes through the front part (accept, 11 steps
// of the bit-serial bin divider, hand-off to the queue; a zero sample or a
// zero bin width skips the divider); the back part then does the counter
// read-modify-write through the memory's single registered read port. The
// front takes a new transaction only after it has handed the last one to the
// queue. A read also goes through the counter lookup; an ignored transaction
// goes straight to the result. The back part takes a new command only after
// its last result is taken. A clear sweeps the memory one counter a cycle and
// then gives its result. The result register and a two-entry command queue
// let the front take the next transaction while a result waits for m_ready.
// The user must write bin_width through cfg_wr_en/cfg_wr_data only while the
// engine is idle; the block itself does not enforce this.
`default_nettype none

module equal_width_histogram #(
    parameter int NUM_BINS    = ewh_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = ewh_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ewh_pkg::OP_W-1:0]            s_op,
    input  wire logic [ewh_pkg::VALUE_W-1:0]         s_sample_value,
    input  wire logic [ewh_pkg::INDEX_W-1:0]         s_read_bin,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ewh_pkg::VALUE_W-1:0]         cfg_wr_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [ewh_pkg::INDEX_W-1:0]         m_bin_index,
    output logic      [ewh_pkg::OUT_COUNT_W-1:0]     m_bin_count,
    output logic                                     m_accepted
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int Q_W   = $bits(ewh_pkg::cmd_t) + BIN_W;

    logic               init_busy;
    logic               fe_valid, fe_ready;
    ewh_pkg::cmd_t      fe_cmd;
    logic [BIN_W-1:0]   fe_addr;
    logic               be_valid, be_ready;
    ewh_pkg::cmd_t      be_cmd;
    logic [BIN_W-1:0]   be_addr;
    logic [Q_W-1:0]     q_in, q_out;

    assign q_in              = {fe_cmd, fe_addr};
    assign {be_cmd, be_addr} = q_out;

    ewh_front #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_sample_value (s_sample_value),
        .s_read_bin     (s_read_bin),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .init_busy      (init_busy),
        .cmd_valid      (fe_valid),
        .cmd_ready      (fe_ready),
        .cmd            (fe_cmd),
        .cmd_addr       (fe_addr)
    );

    ewh_queue #(
        .WIDTH (Q_W),
        .DEPTH (ewh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (q_in),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  (q_out)
    );

    ewh_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .BIN_W       (BIN_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (be_valid),
        .cmd_ready   (be_ready),
        .cmd         (be_cmd),
        .cmd_addr    (be_addr),
        .init_busy   (init_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_bin_count (m_bin_count),
        .m_accepted  (m_accepted)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ewh_checker.sv =====
// ----------------------------------------------------------------------------
// ewh_checker
// Port-level checks for the histogram engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ewh_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [ewh_pkg::INDEX_W-1:0]        m_bin_index,
    input wire logic [ewh_pkg::OUT_COUNT_W-1:0]    m_bin_count,
    input wire logic                               m_accepted
);

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index)
            && $stable(m_bin_count) && $stable(m_accepted))
        else $error("result changed while stalled");

    // the clearing sweep keeps the input closed straight after reset
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during reset sweep");

    // front works on one transaction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken back to back");

    // back returns to idle after a result is taken
    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result repeated");

endmodule

bind equal_width_histogram ewh_checker u_ewh_checker (.*);

`default_nettype wire

// ===== verif/equal_width_histogram_test.sv =====
// ----------------------------------------------------------------------------
// equal_width_histogram_test
// Self-checking bench for the equal-width histogram engine. Sample, read,
// clear and unused transactions are driven over valid/ready with random
// idling on both channels. Every accepted transaction is run through a local
// bin counter model and each result is compared against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_width_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = ewh_pkg::OP_W;
    localparam int VALUE_W = ewh_pkg::VALUE_W;
    localparam int INDEX_W = ewh_pkg::INDEX_W;
    localparam int CNT_W   = ewh_pkg::OUT_COUNT_W;

    localparam int                BINS      = ewh_pkg::NUM_BINS_DEF;
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam int                STALL_MAX = 4000;
    localparam int                PHASE_LEN = 400;

    typedef struct packed {
        logic [INDEX_W-1:0]     index;
        logic [CNT_W-1:0]       count;
        logic                   accepted;
    } hist_result_t;

    // bin counters, bin width and the results still owed by the engine
    class hist_tracker_t;
        bit [ewh_pkg::COUNT_WIDTH_DEF-1:0] bin_model [BINS];
        bit [VALUE_W-1:0]         width_reg = ewh_pkg::BIN_WIDTH_RESET;
        hist_result_t             pending_results [$];
        int unsigned              errors = 0;

        task report(string msg);
            if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function hist_result_t apply_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                          logic [INDEX_W-1:0] rb);
            hist_result_t r;
            int unsigned  b;
            r = '0;
            case (op)
                ewh_pkg::OP_ADD: begin
                    if (value != 0) begin
                        // zero width puts every sample above every limit
                        if (width_reg == 0) b = BINS - 1;
                        else b = (int'(value) - 1) / int'(width_reg);
                        if (b > BINS - 1) b = BINS - 1;
                        if (~bin_model[b] != 0) bin_model[b] += 1'b1;
                        r.index    = b[INDEX_W-1:0];
                        r.count    = bin_model[b];
                        r.accepted = 1'b1;
                    end
                end
                ewh_pkg::OP_READ: begin
                    r.index = rb;
                    if (rb < BINS) r.count = bin_model[rb];
                end
                ewh_pkg::OP_CLEAR: begin
                    foreach (bin_model[i]) bin_model[i] = '0;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                logic [INDEX_W-1:0] rb);
            pending_results.push_back(apply_item(op, value, rb));
        endfunction

        task check_result(logic [INDEX_W-1:0] index, logic [CNT_W-1:0] count,
                          logic accepted);
            hist_result_t e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result bin %0d count %0d", index, count));
            end else begin
                e = pending_results.pop_front();
                if (index !== e.index)
                    report($sformatf("bin_index %0d, want %0d", index, e.index));
                if (count !== e.count)
                    report($sformatf("bin_count %0d, want %0d (bin %0d)",
                                     count, e.count, e.index));
                if (accepted !== e.accepted)
                    report($sformatf("accepted %0b, want %0b (bin %0d)",
                                     accepted, e.accepted, e.index));
            end
        endtask
    endclass

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op           = ewh_pkg::OP_ADD;
    logic [VALUE_W-1:0]     s_sample_value = '0;
    logic [INDEX_W-1:0]     s_read_bin     = '0;
    logic                   cfg_wr_en      = 1'b0;
    logic [VALUE_W-1:0]     cfg_wr_data    = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [INDEX_W-1:0]     m_bin_index;
    logic [CNT_W-1:0]       m_bin_count;
    logic                   m_accepted;

    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;
    int unsigned quiet_cycles = 0;

    int unsigned phase_send  [4] = '{0, 88, 0, 23};
    int unsigned phase_stall [4] = '{0, 0, 88, 23};
    int unsigned phase_width [4] = '{16, 2047, 0, 1};

    hist_tracker_t tracker = new;

    equal_width_histogram u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_sample_value (s_sample_value),
        .s_read_bin     (s_read_bin),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_index    (m_bin_index),
        .m_bin_count    (m_bin_count),
        .m_accepted     (m_accepted)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // result checking and the stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_result(m_bin_index, m_bin_count, m_accepted);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [INDEX_W-1:0] rb);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_sample_value <= value;
        s_read_bin     <= rb;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(op, value, rb);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_results.size() != 0);
    endtask

    task automatic set_width(logic [VALUE_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.width_reg = w;
    endtask

    task automatic send_random();
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int unsigned        pick;
        int unsigned        limit;
        pick = $urandom_range(99);
        if (pick < 68)      op = ewh_pkg::OP_ADD;
        else if (pick < 91) op = ewh_pkg::OP_READ;
        else if (pick < 96) op = ewh_pkg::OP_CLEAR;
        else                op = OP_UNUSED;
        pick = $urandom_range(9);
        if (pick == 0) begin
            value = '0;
        end else if (pick <= 3) begin
            // just on or just past a bin limit
            limit = tracker.width_reg * $urandom_range(BINS) + $urandom_range(1);
            value = (limit >= 1 && limit <= 2047) ? limit[VALUE_W-1:0]
                                                  : VALUE_W'($urandom_range(1, 2047));
        end else if (pick == 4) begin
            value = $urandom_range(1) ? 11'd2047 : 11'd1;
        end else begin
            value = VALUE_W'($urandom_range(2047));
        end
        send_item(op, value, INDEX_W'($urandom_range(BINS - 1)));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width of ten: bin edges, the top bin, ignored and unused items
        send_item(ewh_pkg::OP_READ,  11'd0,    7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd0,    7'd127);
        send_item(ewh_pkg::OP_ADD,   11'd1,    7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd10,   7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd11,   7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd1270, 7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd1271, 7'd0);
        send_item(ewh_pkg::OP_ADD,   11'd2047, 7'd127);
        send_item(ewh_pkg::OP_READ,  11'd0,    7'd127);
        send_item(ewh_pkg::OP_READ,  11'd2047, 7'd0);
        send_item(OP_UNUSED,         11'd2047, 7'd127);
        send_item(ewh_pkg::OP_CLEAR, 11'd2047, 7'd127);
        send_item(ewh_pkg::OP_READ,  11'd0,    7'd127);

        // zero width sends everything to the last bin
        drain();
        set_width(11'd0);
        send_item(ewh_pkg::OP_ADD,  11'd1,    7'd0);
        send_item(ewh_pkg::OP_ADD,  11'd2047, 7'd0);
        send_item(ewh_pkg::OP_READ, 11'd0,    7'd127);

        drain();
        set_width(11'd2047);
        send_item(ewh_pkg::OP_ADD,  11'd2047, 7'd0);
        send_item(ewh_pkg::OP_ADD,  11'd1,    7'd0);
        send_item(ewh_pkg::OP_READ, 11'd0,    7'd0);

        drain();
        set_width(11'd1);
        send_item(ewh_pkg::OP_ADD,  11'd1,    7'd0);
        send_item(ewh_pkg::OP_ADD,  11'd127,  7'd0);
        send_item(ewh_pkg::OP_ADD,  11'd128,  7'd0);
        send_item(ewh_pkg::OP_ADD,  11'd2047, 7'd0);
        send_item(ewh_pkg::OP_READ, 11'd0,    7'd127);

        for (int p = 0; p < 4; p++) begin
            drain();
            set_width(p == 2 ? VALUE_W'($urandom_range(1, 2047)) : VALUE_W'(phase_width[p]));
            send_idle  = phase_send[p];
            recv_stall = phase_stall[p];
            for (int n = 0; n < PHASE_LEN; n++) begin
                // hold the sender back until the engine has caught up
                if (n == PHASE_LEN / 2) drain();
                send_random();
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (tracker.pending_results.size() != 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.pending_results.size()));
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ewh_pkg.sv
hw/rtl/ewh_queue.sv
hw/rtl/ewh_front.sv
hw/rtl/ewh_back.sv
hw/rtl/equal_width_histogram.sv
hw/rtl/ewh_checker.sv
verif/equal_width_histogram_test.sv
